// ----- hw/rtl/peer_liveness_registry_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Peer liveness registry assertion macros
// Small wrappers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef PEER_LIVENESS_REGISTRY_UNIT_ASSERT_SVH
`define PEER_LIVENESS_REGISTRY_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define PLR_ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("plr: invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define PLR_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("plr: implication violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define PLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("plr: next-cycle check violated");

`endif

// ----- hw/rtl/plr_pkg.sv -----
// ----------------------------------------------------------------------------
// Peer liveness registry package
// Shared constants, codes and types of the registry blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package plr_pkg;

  localparam int unsigned TableDepth  = 32;
  localparam int unsigned MaxResults  = 32;
  localparam int unsigned ResCntW     = 6;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Action codes on the input beat.
  localparam logic [2:0] ACT_REGISTER  = 3'd0;
  localparam logic [2:0] ACT_HEARTBEAT = 3'd1;
  localparam logic [2:0] ACT_ACK       = 3'd2;
  localparam logic [2:0] ACT_SHUTDOWN  = 3'd3;
  localparam logic [2:0] ACT_LIST      = 3'd4;
  localparam logic [2:0] ACT_SWEEP     = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_STALE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PING_IVL  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PINGS = 2'd2;

  localparam logic [15:0] StaleReset    = 16'd600;
  localparam logic [15:0] PingIvlReset  = 16'd10;
  localparam logic [3:0]  MaxPingsReset = 4'd6;

  typedef enum logic [2:0] {
    OP_REG   = 3'd0,
    OP_HB    = 3'd1,
    OP_ACK   = 3'd2,
    OP_SD    = 3'd3,
    OP_LIST  = 3'd4,
    OP_SWEEP = 3'd5,
    OP_NONE  = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    KIND_NOTHING = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_PING    = 3'd2,
    KIND_ENTRY   = 3'd3,
    KIND_EMPTY   = 3'd4,
    KIND_FULL    = 3'd5
  } kind_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] now;
    logic [31:0] ip;
    logic [15:0] port;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] ip;
    logic [15:0] port;
  } result_t;

  typedef struct packed {
    logic [15:0] stale;
    logic [15:0] ping_ivl;
    logic [3:0]  max_pings;
  } cfg_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [3:0]  unans;
    logic [1:0]  acks;
    logic [31:0] heard;
    logic [31:0] pinged;
    logic        sd;
    logic        val;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/peer_liveness_registry_unit.sv -----
// ----------------------------------------------------------------------------
// Peer liveness registry
// Table of peers keyed by address and port, driven by classified events.
// ----------------------------------------------------------------------------
// Usage:
// Events arrive as beats on the s_axis channel, one event per beat. Results
// leave on the m_axis channel; every event gives one or more result beats and
// the final beat of an event carries m_axis_tlast. Configuration registers
// are written through cfg_we_i, cfg_idx_i and cfg_data_i while the block is
// idle; a write to index 3 is ignored.
// Timing: an event waits in a two-beat queue, then the back end walks the
// whole table once, one entry per cycle while no output stall holds it,
// rotating it as a ring. The back end takes no new event until the walk is
// over and the final result of the last event is in the output register;
// earlier results of a list or sweep leave while the walk goes on. The
// table walk sets the throughput.
// Reset clears the table (entry count zero) and loads the register defaults
// of 600, 10 and 6. When the receiver stalls, one result waits in the output
// register and one more in a hold stage; the walk pauses only when a third
// result is due, while the input queue still takes beats until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_liveness_registry_unit #(
  parameter int unsigned TABLE_DEPTH = plr_pkg::TableDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // s_axis_tdata: action[2:0], now_seconds[34:3], peer_ip[66:35],
  // peer_port[82:67], zero fill above.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [plr_pkg::InDataW-1:0]   s_axis_tdata,
  // m_axis_tdata: kind[2:0], target_ip[34:3], target_port[50:35],
  // zero fill above.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [plr_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_we_i,
  input  wire logic [plr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [plr_pkg::CfgDataW-1:0]  cfg_data_i
);

  plr_pkg::cfg_t    cfg_q;
  plr_pkg::item_t   ev;
  plr_pkg::result_t res;
  logic             ev_valid, ev_ready;

  // Configuration registers; the index decides which one takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale     <= plr_pkg::StaleReset;
      cfg_q.ping_ivl  <= plr_pkg::PingIvlReset;
      cfg_q.max_pings <= plr_pkg::MaxPingsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plr_pkg::CFG_STALE:     cfg_q.stale     <= cfg_data_i;
        plr_pkg::CFG_PING_IVL:  cfg_q.ping_ivl  <= cfg_data_i;
        plr_pkg::CFG_MAX_PINGS: cfg_q.max_pings <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  plr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tdata[2:0]),
    .now_i      (s_axis_tdata[34:3]),
    .ip_i       (s_axis_tdata[66:35]),
    .port_i     (s_axis_tdata[82:67]),
    .ev_valid_o (ev_valid),
    .ev_ready_i (ev_ready),
    .ev_o       (ev)
  );

  plr_back #(
    .DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ev_valid_i  (ev_valid),
    .ev_ready_o  (ev_ready),
    .ev_i        (ev),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res),
    .res_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, res.port, res.ip, res.kind};

endmodule

`default_nettype wire

// ----- hw/rtl/plr_front.sv -----
// ----------------------------------------------------------------------------
// Peer liveness registry front end
// Accepts input beats, decodes the action and queues classified events.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [2:0]           action_i,
  input  wire logic [31:0]          now_i,
  input  wire logic [31:0]          ip_i,
  input  wire logic [15:0]          port_i,
  output logic                      ev_valid_o,
  input  wire logic                 ev_ready_i,
  output plr_pkg::item_t            ev_o
);

  plr_pkg::item_t fifo_q [2];
  plr_pkg::item_t cls;
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     fill_q, fill_d;
  logic           push, pop;

  // Unused action codes become a no-op event.
  always_comb begin
    cls.now  = now_i;
    cls.ip   = ip_i;
    cls.port = port_i;
    case (action_i)
      plr_pkg::ACT_REGISTER:  cls.op = plr_pkg::OP_REG;
      plr_pkg::ACT_HEARTBEAT: cls.op = plr_pkg::OP_HB;
      plr_pkg::ACT_ACK:       cls.op = plr_pkg::OP_ACK;
      plr_pkg::ACT_SHUTDOWN:  cls.op = plr_pkg::OP_SD;
      plr_pkg::ACT_LIST:      cls.op = plr_pkg::OP_LIST;
      plr_pkg::ACT_SWEEP:     cls.op = plr_pkg::OP_SWEEP;
      default:                cls.op = plr_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o = (fill_q != 2'd2);
  assign ev_valid_o = (fill_q != 2'd0);
  assign ev_o       = fifo_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = ev_valid_o && ev_ready_i;

  always_comb begin
    wp_d   = push ? ~wp_q : wp_q;
    rp_d   = pop ? ~rp_q : rp_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/plr_back.sv -----
// ----------------------------------------------------------------------------
// Peer liveness registry back end
// Keeps the peer table as a rotating ring and carries out one event per pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "peer_liveness_registry_unit_assert.svh"

module plr_back #(
  parameter int unsigned DEPTH = plr_pkg::TableDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  plr_pkg::cfg_t          cfg_i,
  input  wire logic              ev_valid_i,
  output logic                   ev_ready_o,
  input  plr_pkg::item_t         ev_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output plr_pkg::result_t       res_o,
  output logic                   res_last_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e                         state_q, state_d;
  plr_pkg::item_t                 item_q;
  logic [CW-1:0]                  cnt_q, cnt_d, rem_q, rem_d, cnt_m1;
  logic [plr_pkg::ResCntW-1:0]    n_q, n_d;
  logic                           found_q, found_d, readd_q, readd_d;
  logic                           held_v_q, held_v_d, out_v_q, out_v_d, out_last_q, out_last_d;
  plr_pkg::result_t               held_q, held_d, out_q, out_d;
  plr_pkg::entry_t                tbl_q [DEPTH];

  plr_pkg::entry_t                head, upd, fresh;
  plr_pkg::result_t               emit_r, fin_r;
  logic                           match, keep, emit_req, fin_v, stall, out_free;
  logic                           shift_en, app_we;
  logic [31:0]                    heard_age, ping_age;
  logic                           room;

  assign head      = tbl_q[0];
  assign match     = (head.ip == item_q.ip) && (head.port == item_q.port);
  assign heard_age = item_q.now - head.heard;
  assign ping_age  = item_q.now - head.pinged;
  assign out_free  = !out_v_q || res_ready_i;
  assign cnt_m1    = cnt_q - CW'(1);
  assign room      = (cnt_q < CW'(DEPTH));
  assign ev_ready_o = (state_q == ST_IDLE);

  always_comb begin
    fresh.ip     = item_q.ip;
    fresh.port   = item_q.port;
    fresh.unans  = 4'd0;
    fresh.acks   = 2'd0;
    fresh.heard  = item_q.now;
    fresh.pinged = 32'd0;
    fresh.sd     = 1'b0;
    fresh.val    = 1'b0;
  end

  // Work on the entry at the head of the ring.
  always_comb begin
    upd         = head;
    keep        = 1'b1;
    emit_req    = 1'b0;
    emit_r.kind = plr_pkg::KIND_ENTRY;
    emit_r.ip   = head.ip;
    emit_r.port = head.port;
    found_d     = found_q;
    readd_d     = readd_q;
    case (item_q.op)
      plr_pkg::OP_REG: begin
        if (match) begin
          found_d = 1'b1;
          if (head.sd) begin
            keep    = 1'b0;
            readd_d = 1'b1;
          end
        end
      end
      plr_pkg::OP_HB: begin
        if (match) begin
          found_d   = 1'b1;
          upd.val   = 1'b1;
          upd.heard = item_q.now;
        end
      end
      plr_pkg::OP_ACK: begin
        if (match) begin
          upd.heard = item_q.now;
          upd.unans = 4'd0;
          if (head.acks != 2'd3) upd.acks = head.acks + 2'd1;
        end
      end
      plr_pkg::OP_SD: begin
        if (match) begin
          found_d = 1'b1;
          upd.sd  = 1'b1;
        end
      end
      plr_pkg::OP_LIST: begin
        if (head.acks[1] && !head.sd && head.val &&
            (n_q < plr_pkg::ResCntW'(plr_pkg::MaxResults))) begin
          emit_req = 1'b1;
        end
      end
      plr_pkg::OP_SWEEP: begin
        if (heard_age > {16'd0, cfg_i.stale}) begin
          if (head.sd || (head.unans > cfg_i.max_pings)) begin
            keep = 1'b0;
          end else if ((ping_age >= {16'd0, cfg_i.ping_ivl}) &&
                       (n_q < plr_pkg::ResCntW'(plr_pkg::MaxResults))) begin
            emit_req    = 1'b1;
            emit_r.kind = plr_pkg::KIND_PING;
            upd.pinged  = item_q.now;
            if (head.unans != 4'd15) upd.unans = head.unans + 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result that closes the event.
  always_comb begin
    fin_v      = 1'b0;
    app_we     = 1'b0;
    fin_r.kind = plr_pkg::KIND_ACK;
    fin_r.ip   = item_q.ip;
    fin_r.port = item_q.port;
    case (item_q.op)
      plr_pkg::OP_REG, plr_pkg::OP_HB: begin
        if (item_q.op == plr_pkg::OP_HB && found_q) begin
          fin_v = 1'b1;
        end else if (!found_q || readd_q) begin
          if (room) begin
            app_we = 1'b1;
            fin_v  = (item_q.op == plr_pkg::OP_REG);
          end else begin
            fin_v      = 1'b1;
            fin_r.kind = plr_pkg::KIND_FULL;
          end
        end
      end
      plr_pkg::OP_SD: begin
        fin_v      = found_q;
        fin_r.kind = plr_pkg::KIND_PING;
      end
      plr_pkg::OP_LIST: begin
        fin_v      = (n_q == '0);
        fin_r.kind = plr_pkg::KIND_EMPTY;
        fin_r.ip   = 32'd0;
        fin_r.port = 16'd0;
      end
      default: ;
    endcase
  end

  assign stall = emit_req && held_v_q && !out_free;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    n_d        = n_q;
    held_v_d   = held_v_q;
    held_d     = held_q;
    out_v_d    = out_v_q && !res_ready_i;
    out_d      = out_q;
    out_last_d = out_last_q;
    shift_en   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (ev_valid_i) begin
          rem_d   = cnt_q;
          n_d     = '0;
          state_d = (cnt_q == '0) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          shift_en = 1'b1;
          rem_d    = rem_q - CW'(1);
          if (!keep) cnt_d = cnt_m1;
          if (emit_req) begin
            n_d = n_q + plr_pkg::ResCntW'(1);
            if (held_v_q) begin
              out_v_d    = 1'b1;
              out_d      = held_q;
              out_last_d = 1'b0;
            end
            held_v_d = 1'b1;
            held_d   = emit_r;
          end
          if (rem_q == CW'(1)) state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          if (fin_v) begin
            out_d = fin_r;
          end else if (held_v_q) begin
            out_d = held_q;
          end else begin
            out_d.kind = plr_pkg::KIND_NOTHING;
            out_d.ip   = 32'd0;
            out_d.port = 16'd0;
          end
          held_v_d = 1'b0;
          if (app_we) cnt_d = cnt_q + CW'(1);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      n_q      <= '0;
      found_q  <= 1'b0;
      readd_q  <= 1'b0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      n_q      <= n_d;
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
      if (state_q == ST_IDLE) begin
        found_q <= 1'b0;
        readd_q <= 1'b0;
      end else if (state_q == ST_SCAN && !stall) begin
        found_q <= found_d;
        readd_q <= readd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    if (state_q == ST_IDLE && ev_valid_i) begin
      item_q <= ev_i;
    end
  end

  // Ring rotation: every entry moves one place toward the head, and the
  // processed head, unless dropped, goes to the tail of the live region.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < int'(DEPTH) - 1; i++) begin
        if (keep && (cnt_m1 == CW'(i))) begin
          tbl_q[i] <= upd;
        end else begin
          tbl_q[i] <= tbl_q[i + 1];
        end
      end
      if (keep && (cnt_m1 == CW'(DEPTH - 1))) begin
        tbl_q[DEPTH - 1] <= upd;
      end
    end else if (state_q == ST_FIN && out_free && app_we) begin
      tbl_q[cnt_q[IW-1:0]] <= fresh;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;
  assign res_last_o  = out_last_q;

  `PLR_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `PLR_ASSERT_ALWAYS(a_res_bound, clk_i, rst_ni,
                     n_q <= plr_pkg::ResCntW'(plr_pkg::MaxResults))
  `PLR_ASSERT_IMPLIES(a_idle_no_held, clk_i, rst_ni, state_q == ST_IDLE, !held_v_q)
  `PLR_ASSERT_IMPLIES(a_scan_rem, clk_i, rst_ni, state_q == ST_SCAN, rem_q != '0)
  `PLR_ASSERT_NEXT(a_fin_done, clk_i, rst_ni, state_q == ST_FIN && out_free,
                   state_q == ST_IDLE && out_v_q && out_last_q)

endmodule

`default_nettype wire
